/* hdl/ffbp_pkg.sv */
// Shared constants, types and helpers for the first-fit bin packer.
package ffbp_pkg;

  localparam int NUM_BINS = 128;
  localparam int IDX_W    = $clog2(NUM_BINS);

  localparam int TOTAL_W  = 32;
  localparam int OVH_W    = 16;
  localparam int BIN_W    = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [TOTAL_W-1:0] CAPACITY_RESET = 32'd63000;
  localparam logic [OVH_W-1:0]   BIN_OVH_RESET  = 16'd620;
  localparam logic [OVH_W-1:0]   ITEM_OVH_RESET = 16'd90;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_OVH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_OVH = 8'd2;

  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic advance;
    logic commit;
    logic load_out;
  } ffbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic last;
  } ffbp_status_t;

  // Reports a bin number on the 7-bit result fields, masked or zero-extended.
  function automatic logic [BIN_W-1:0] to_bin_field(input logic [IDX_W-1:0] v);
    logic [IDX_W+BIN_W-1:0] w;
    w = {{BIN_W{1'b0}}, v};
    return w[BIN_W-1:0];
  endfunction

endpackage

/* hdl/first_fit_bin_packer_core.sv */
// Top level of the first-fit bin packer: controller, datapath and handshake ports.
//
// Usage: one item (item_size, is_directory) is taken per transfer on the input
// channel (in_valid/in_ready). The core scans bins from 1 upward and returns one
// result per item on the output channel (out_valid/out_ready): the chosen bin, its
// new saturated total, whether that bin was newly opened, the highest open bin,
// and a flag when every bin rejected the item.
// Configuration (capacity, per-bin and per-item overhead) is written through the
// cfg channel, which is always ready; writes should only be made while idle, and
// an index beyond the three registers is ignored.
// Scan: the core reads one bin total per cycle from the total memory, which has
// one read and one write port, and stops at the first bin that fits, at the latest
// one past the highest open; a rejected item is scanned up to the last bin.
// One item is processed at a time; the next is taken once the result is latched.
// Reset clears the open-bin count and restores the configuration defaults; the
// total memory needs no clearing, as unopened bins read as zero.
// If the receiver stalls, the result is held in the output register and the core
// may accept and scan the next item, waiting to deliver it until the slot frees.
module first_fit_bin_packer_core
  import ffbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TOTAL_W-1:0]    item_size,
  input  logic                  is_directory,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BIN_W-1:0]      bin_index,
  output logic [TOTAL_W-1:0]    bin_total,
  output logic                  opened_new_bin,
  output logic [BIN_W-1:0]      bins_in_use,
  output logic                  no_bin_free
);

  ffbp_cmd_t    cmd;
  ffbp_status_t status;

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  ffbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ffbp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_size      (item_size),
    .is_directory   (is_directory),
    .bin_index      (bin_index),
    .bin_total      (bin_total),
    .opened_new_bin (opened_new_bin),
    .bins_in_use    (bins_in_use),
    .no_bin_free    (no_bin_free)
  );

endmodule

/* hdl/ffbp_ctrl.sv */
// Controller state machine sequencing the first-fit scan of one item.
module ffbp_ctrl
  import ffbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ffbp_status_t status,
  output ffbp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:  cmd.load_item = in_valid;
      ST_START: cmd.advance = 1'b1;
      ST_SCAN: begin
        cmd.advance = 1'b1;
        cmd.commit  = status.hit || status.last;
      end
      ST_DONE:  cmd.load_out = slot_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result is loaded when the slot frees; otherwise a held result stays until taken.
      out_valid <= ((state == ST_DONE) && slot_free) || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_START;
          end
        end
        ST_START: state <= ST_SCAN;
        ST_SCAN: begin
          if (status.hit || status.last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/ffbp_datapath.sv */
// Datapath: configuration registers, bin total memory, fit test and result registers.
module ffbp_datapath
  import ffbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ffbp_cmd_t             cmd,
  output ffbp_status_t          status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TOTAL_W-1:0]    item_size,
  input  logic                  is_directory,
  output logic [BIN_W-1:0]      bin_index,
  output logic [TOTAL_W-1:0]    bin_total,
  output logic                  opened_new_bin,
  output logic [BIN_W-1:0]      bins_in_use,
  output logic                  no_bin_free
);

  logic [TOTAL_W-1:0] bin_capacity;
  logic [OVH_W-1:0]   bin_overhead;
  logic [OVH_W-1:0]   item_overhead;

  logic [TOTAL_W-1:0] totals_mem [NUM_BINS];
  logic [TOTAL_W-1:0] rdata;

  logic [IDX_W-1:0]   highest;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   chk_idx;

  logic [TOTAL_W:0]   addend;
  logic [TOTAL_W-1:0] limit;
  logic               limit_ok;
  logic               unlimited;

  logic [IDX_W-1:0]   res_idx;
  logic [TOTAL_W-1:0] res_total;
  logic               res_opened;
  logic [IDX_W-1:0]   res_bins;
  logic               res_fail;

  logic               empty;
  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W+1:0] sum;
  logic [TOTAL_W-1:0] stored;
  logic               fit;

  // Bins above the highest opened one are treated as empty and read as zero.
  assign empty  = chk_idx > highest;
  assign base   = empty ? '0 : rdata;
  assign sum    = {2'b00, base} + {1'b0, addend};
  assign stored = (sum[TOTAL_W+1:TOTAL_W] != 2'b00) ? '1 : sum[TOTAL_W-1:0];
  assign fit    = unlimited || empty ||
                  (limit_ok && (sum <= {2'b00, limit}));

  assign status.hit  = fit;
  assign status.last = (chk_idx == LAST_BIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity  <= CAPACITY_RESET;
      bin_overhead  <= BIN_OVH_RESET;
      item_overhead <= ITEM_OVH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: bin_capacity  <= cfg_data;
        CFG_BIN_OVH:  bin_overhead  <= cfg_data[OVH_W-1:0];
        CFG_ITEM_OVH: item_overhead <= cfg_data[OVH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rdata <= totals_mem[rd_addr];
    if (cmd.commit && fit) begin
      totals_mem[chk_idx] <= stored;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '0;
    end else if (cmd.commit && fit && empty) begin
      highest <= chk_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      addend    <= (is_directory ? {1'b0, {TOTAL_W{1'b0}}} : {1'b0, item_size}) +
                   {{(TOTAL_W-OVH_W+1){1'b0}}, item_overhead};
      unlimited <= (bin_capacity == '0);
      limit_ok  <= (bin_capacity != '0) &&
                   (bin_capacity >= {{(TOTAL_W-OVH_W){1'b0}}, bin_overhead});
      limit     <= bin_capacity - {{(TOTAL_W-OVH_W){1'b0}}, bin_overhead};
      rd_addr   <= IDX_W'(1);
    end else if (cmd.advance) begin
      rd_addr <= rd_addr + IDX_W'(1);
      chk_idx <= rd_addr;
    end
    if (cmd.commit) begin
      if (fit) begin
        res_idx    <= chk_idx;
        res_total  <= stored;
        res_opened <= empty;
        res_bins   <= empty ? chk_idx : highest;
        res_fail   <= 1'b0;
      end else begin
        res_idx    <= '0;
        res_total  <= '0;
        res_opened <= 1'b0;
        res_bins   <= highest;
        res_fail   <= 1'b1;
      end
    end
    if (cmd.load_out) begin
      bin_index      <= to_bin_field(res_idx);
      bin_total      <= res_total;
      opened_new_bin <= res_opened;
      bins_in_use    <= to_bin_field(res_bins);
      no_bin_free    <= res_fail;
    end
  end

  // The count of open bins never shrinks outside reset.
  assert property (@(posedge clk) disable iff (rst) 1'b1 |=> highest >= $past(highest))
    else $error("highest opened bin decreased");

  // First fit never skips an unopened bin.
  assert property (@(posedge clk) disable iff (rst)
      cmd.commit && fit |-> ({1'b0, chk_idx} <= {1'b0, highest} + 1'b1))
    else $error("placement beyond the lowest unopened bin");

  // A rejected item is only reported once bins 1 to the last are all open and checked.
  assert property (@(posedge clk) disable iff (rst)
      cmd.commit && !fit |-> (chk_idx == LAST_BIN) && (highest == LAST_BIN))
    else $error("no-bin-free reported with bins left");

endmodule
